// ----- rtl/contact_impulse_resolver_macros.svh -----
// assertion macros used by the checker file
`ifndef CONTACT_IMPULSE_RESOLVER_MACROS_SVH
`define CONTACT_IMPULSE_RESOLVER_MACROS_SVH

// same-cycle implication, masked during reset
`define CIR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cir check failed");

// next-cycle implication, masked during reset
`define CIR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cir check failed");

// next-cycle implication that also covers reset cycles
`define CIR_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("cir check failed");

`endif

// ----- rtl/cir_pkg.sv -----
// shared types, codes and saturating helpers for the contact resolver
package cir_pkg;

    localparam logic [1:0] KIND_STATIC  = 2'd0;
    localparam logic [1:0] KIND_DYNAMIC = 2'd1;

    localparam logic [16:0] REST_RESET = 17'd65536;

    localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

    typedef struct packed {
        logic [63:0]        vel_a;
        logic [63:0]        vel_b;
        logic [63:0]        pos_a;
        logic [63:0]        pos_b;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic [31:0]        im_a;
        logic [31:0]        im_b;
        logic [32:0]        total;
        logic signed [31:0] depth;
        logic [1:0]         kind_a;
        logic [1:0]         kind_b;
        logic               sw;
        logic               tot_nz;
        logic               dep_pos;
        logic               sep_le0;
        logic               neg_j;
        logic               neg_m;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > S32_MAX_W) return 32'sh7FFF_FFFF;
        if (v < S32_MIN_W) return 32'sh8000_0000;
        return signed'(v[31:0]);
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [65:0] ea;
        logic signed [65:0] eb;
        ea = a;
        eb = b;
        return sat32(ea + eb);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [65:0] ea;
        logic signed [65:0] eb;
        ea = a;
        eb = b;
        return sat32(ea - eb);
    endfunction

    function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
        logic signed [65:0] ea;
        ea = a;
        return sat32(-ea);
    endfunction

endpackage

// ----- rtl/contact_impulse_resolver.sv -----
// 2d contact resolver: impulse and penetration correction, deep pipeline
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | sink      | i_in_valid / o_in_ready  | vel, pos, dir, inv mass, depth, kinds
//  out     | source    | o_out_valid / i_out_ready| new vel, new pos, two flags
//  cfg     | sink      | i_cfg_valid / o_cfg_ready| restitution, unsigned Q.FRAC_BITS
//
//  one beat enters per cycle while the pipe is not stalled; most of the stages form
//  the two restoring dividers (one quotient bit per stage, 32 + FRAC_BITS stages)
//  each stage holds its beat while the stage after it is full and stalled,
//  so bubbles close up and nothing is dropped or repeated
//  reset is synchronous, active low; clears valid bits, restitution returns to 1.0
//  the cfg port is always ready
module contact_impulse_resolver
    import cir_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [63:0]        i_vel_a,
    input  logic [63:0]        i_vel_b,
    input  logic [63:0]        i_pos_a,
    input  logic [63:0]        i_pos_b,
    input  logic [63:0]        i_contact_dir,
    input  logic [31:0]        i_inv_mass_a,
    input  logic [31:0]        i_inv_mass_b,
    input  logic signed [31:0] i_depth,
    input  logic [3:0]         i_body_kinds,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [63:0]        o_new_vel_a,
    output logic [63:0]        o_new_vel_b,
    output logic [63:0]        o_new_pos_a,
    output logic [63:0]        o_new_pos_b,
    output logic               o_impulse_applied,
    output logic               o_moved_apart,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [16:0]        i_cfg_restitution
);

    // divider word: magnitude of numerator scaled by 2^FRAC_BITS
    localparam int NW    = 32 + FRAC_BITS;
    // stage map
    localparam int KD0   = 5;          // divider load
    localparam int KPOST = 6 + NW;     // quotient sign and saturation
    localparam int KJM   = 7 + NW;     // normal times j and m
    localparam int KFS   = 8 + NW;     // floor and saturate
    localparam int KIM   = 9 + NW;     // times inverse masses
    localparam int KOUT  = 10 + NW;    // apply and output register
    localparam int NS    = 11 + NW;

    localparam logic [NW-1:0] Q_POS_LIM = NW'(32'h7FFF_FFFF);
    localparam logic [NW-1:0] Q_NEG_LIM = NW'(32'h8000_0000);

    // product floored by FRAC_BITS then clipped to 32 bits
    function automatic logic signed [31:0] fsat(input logic signed [65:0] p);
        return sat32(p >>> FRAC_BITS);
    endfunction

    // signed saturating quotient from magnitude and sign
    function automatic logic signed [31:0] qsat(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] qn;
        qn = -q;
        if (neg) begin
            if (q > Q_NEG_LIM) return 32'sh8000_0000;
            return signed'(qn[31:0]);
        end
        if (q > Q_POS_LIM) return 32'sh7FFF_FFFF;
        return signed'(q[31:0]);
    endfunction

    // apply a correction with a direction
    function automatic logic signed [31:0] upd(input logic signed [31:0] v,
                                               input logic signed [65:0] d,
                                               input logic plus);
        if (plus) return sat_add(v, fsat(d));
        return sat_sub(v, fsat(d));
    endfunction

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic [16:0] r_rest;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= REST_RESET;
        end else if (i_cfg_valid) begin
            r_rest <= i_cfg_restitution;
        end
    end

    // ---------------------------------------------------------------
    // flow control: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_adv;

    always_comb begin
        w_adv[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // side data that rides along with every beat
    // ---------------------------------------------------------------
    t_side r_side [NS];
    t_side n_side [NS];

    // stage 0 operands
    logic signed [31:0] w_vax, w_vay, w_vbx, w_vby, w_nx_in, w_ny_in;
    logic               w_sw;
    // stage 2 separating velocity
    logic signed [65:0] w_ex, w_ey;
    logic signed [31:0] w_sep;
    // stage 5 numerators
    logic signed [31:0] w_nd;

    // stage registers
    logic signed [31:0] r_rx, r_ry;
    logic signed [63:0] r_prx, r_pry;
    logic signed [31:0] r_sep, r_nsep, r_sep3, r_delta;
    logic signed [65:0] r_pr;
    logic [NW-1:0]      r_wj [NW+1];
    logic [NW-1:0]      r_wm [NW+1];
    logic [32:0]        r_rj [NW+1];
    logic [32:0]        r_rm [NW+1];
    logic signed [31:0] r_j, r_m;
    logic signed [63:0] r_pjx, r_pjy, r_pmx, r_pmy;
    logic signed [31:0] r_jx, r_jy, r_mx, r_my;
    logic signed [65:0] r_dvax, r_dvay, r_dvbx, r_dvby;
    logic signed [65:0] r_dpax, r_dpay, r_dpbx, r_dpby;
    logic [63:0]        r_o_vel_a, r_o_vel_b, r_o_pos_a, r_o_pos_b;
    logic               r_o_imp, r_o_mov;

    assign w_vax   = signed'(i_vel_a[31:0]);
    assign w_vay   = signed'(i_vel_a[63:32]);
    assign w_vbx   = signed'(i_vel_b[31:0]);
    assign w_vby   = signed'(i_vel_b[63:32]);
    assign w_nx_in = signed'(i_contact_dir[31:0]);
    assign w_ny_in = signed'(i_contact_dir[63:32]);
    // a static first body trades places with the second
    assign w_sw    = (i_body_kinds[1:0] == KIND_STATIC);

    // separating velocity from floored products
    assign w_ex  = r_prx;
    assign w_ey  = r_pry;
    assign w_sep = sat32((w_ex >>> FRAC_BITS) + (w_ey >>> FRAC_BITS));

    // penetration numerator is -depth
    assign w_nd  = sat_neg(r_side[KD0-1].depth);

    always_comb begin
        n_side[0].vel_a   = i_vel_a;
        n_side[0].vel_b   = i_vel_b;
        n_side[0].pos_a   = i_pos_a;
        n_side[0].pos_b   = i_pos_b;
        n_side[0].nx      = w_sw ? sat_neg(w_nx_in) : w_nx_in;
        n_side[0].ny      = w_sw ? sat_neg(w_ny_in) : w_ny_in;
        n_side[0].im_a    = i_inv_mass_a;
        n_side[0].im_b    = i_inv_mass_b;
        n_side[0].total   = {1'b0, i_inv_mass_a} + {1'b0, i_inv_mass_b};
        n_side[0].depth   = i_depth;
        n_side[0].kind_a  = i_body_kinds[1:0];
        n_side[0].kind_b  = i_body_kinds[3:2];
        n_side[0].sw      = w_sw;
        n_side[0].tot_nz  = (i_inv_mass_a != 32'd0) || (i_inv_mass_b != 32'd0);
        n_side[0].dep_pos = (i_depth > 32'sd0);
        n_side[0].sep_le0 = 1'b0;
        n_side[0].neg_j   = 1'b0;
        n_side[0].neg_m   = 1'b0;
        for (int k = 1; k < NS; k++) begin
            n_side[k] = r_side[k-1];
        end
        // flags settled along the way
        n_side[2].sep_le0  = (w_sep <= 32'sd0);
        n_side[KD0].neg_j  = r_delta[31];
        n_side[KD0].neg_m  = w_nd[31];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_adv[k]) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // velocity path up to the impulse numerator
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // relative velocity in resolution order
        if (w_adv[0]) begin
            r_rx <= w_sw ? sat_sub(w_vbx, w_vax) : sat_sub(w_vax, w_vbx);
            r_ry <= w_sw ? sat_sub(w_vby, w_vay) : sat_sub(w_vay, w_vby);
        end
        // dot product terms
        if (w_adv[1]) begin
            r_prx <= r_rx * r_side[0].nx;
            r_pry <= r_ry * r_side[0].ny;
        end
        if (w_adv[2]) begin
            r_sep  <= w_sep;
            r_nsep <= sat_neg(w_sep);
        end
        // bounce term
        if (w_adv[3]) begin
            r_pr   <= 66'(r_nsep) * 66'(signed'({1'b0, r_rest}));
            r_sep3 <= r_sep;
        end
        if (w_adv[4]) begin
            r_delta <= sat_sub(fsat(r_pr), r_sep3);
        end
    end

    // ---------------------------------------------------------------
    // two restoring dividers sharing the total inverse mass
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv[KD0]) begin
            r_wj[0] <= {(r_delta[31] ? 32'(-r_delta) : 32'(r_delta)),
                        {FRAC_BITS{1'b0}}};
            r_wm[0] <= {(w_nd[31] ? 32'(-w_nd) : 32'(w_nd)), {FRAC_BITS{1'b0}}};
            r_rj[0] <= '0;
            r_rm[0] <= '0;
        end
    end

    for (genvar d = 1; d <= NW; d++) begin : g_div
        logic [33:0] w_tj, w_tm, w_den;
        logic        w_gej, w_gem;

        assign w_den = {1'b0, r_side[KD0+d-1].total};
        assign w_tj  = {r_rj[d-1], r_wj[d-1][NW-1]};
        assign w_tm  = {r_rm[d-1], r_wm[d-1][NW-1]};
        assign w_gej = (w_tj >= w_den);
        assign w_gem = (w_tm >= w_den);

        always_ff @(posedge i_clk) begin
            if (w_adv[KD0+d]) begin
                r_rj[d] <= w_gej ? 33'(w_tj - w_den) : w_tj[32:0];
                r_rm[d] <= w_gem ? 33'(w_tm - w_den) : w_tm[32:0];
                r_wj[d] <= {r_wj[d-1][NW-2:0], w_gej};
                r_wm[d] <= {r_wm[d-1][NW-2:0], w_gem};
            end
        end
    end

    // ---------------------------------------------------------------
    // spread j and m along the normal, then scale by inverse masses
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv[KPOST]) begin
            r_j <= qsat(r_wj[NW], r_side[KPOST-1].neg_j);
            r_m <= qsat(r_wm[NW], r_side[KPOST-1].neg_m);
        end
        if (w_adv[KJM]) begin
            r_pjx <= r_side[KPOST].nx * r_j;
            r_pjy <= r_side[KPOST].ny * r_j;
            r_pmx <= r_side[KPOST].nx * r_m;
            r_pmy <= r_side[KPOST].ny * r_m;
        end
        if (w_adv[KFS]) begin
            r_jx <= fsat(66'(r_pjx));
            r_jy <= fsat(66'(r_pjy));
            r_mx <= fsat(66'(r_pmx));
            r_my <= fsat(66'(r_pmy));
        end
        if (w_adv[KIM]) begin
            r_dvax <= 66'(r_jx) * 66'(signed'({1'b0, r_side[KFS].im_a}));
            r_dvay <= 66'(r_jy) * 66'(signed'({1'b0, r_side[KFS].im_a}));
            r_dvbx <= 66'(r_jx) * 66'(signed'({1'b0, r_side[KFS].im_b}));
            r_dvby <= 66'(r_jy) * 66'(signed'({1'b0, r_side[KFS].im_b}));
            r_dpax <= 66'(r_mx) * 66'(signed'({1'b0, r_side[KFS].im_a}));
            r_dpay <= 66'(r_my) * 66'(signed'({1'b0, r_side[KFS].im_a}));
            r_dpbx <= 66'(r_mx) * 66'(signed'({1'b0, r_side[KFS].im_b}));
            r_dpby <= 66'(r_my) * 66'(signed'({1'b0, r_side[KFS].im_b}));
        end
    end

    // ---------------------------------------------------------------
    // apply to dynamic bodies in input order; output register
    // ---------------------------------------------------------------
    t_side w_s;
    logic  w_app_v, w_app_p, w_dyn_a, w_dyn_b, w_plus_a;

    assign w_s      = r_side[KIM];
    assign w_app_v  = w_s.tot_nz && w_s.sep_le0;
    assign w_app_p  = w_s.tot_nz && w_s.dep_pos;
    assign w_dyn_a  = (w_s.kind_a == KIND_DYNAMIC);
    assign w_dyn_b  = (w_s.kind_b == KIND_DYNAMIC);
    // the body resolved first gets the plus sign
    assign w_plus_a = !w_s.sw;

    always_ff @(posedge i_clk) begin
        if (w_adv[KOUT]) begin
            r_o_vel_a <= (w_app_v && w_dyn_a)
                ? {upd(signed'(w_s.vel_a[63:32]), r_dvay, w_plus_a),
                   upd(signed'(w_s.vel_a[31:0]),  r_dvax, w_plus_a)}
                : w_s.vel_a;
            r_o_vel_b <= (w_app_v && w_dyn_b)
                ? {upd(signed'(w_s.vel_b[63:32]), r_dvby, !w_plus_a),
                   upd(signed'(w_s.vel_b[31:0]),  r_dvbx, !w_plus_a)}
                : w_s.vel_b;
            r_o_pos_a <= (w_app_p && w_dyn_a)
                ? {upd(signed'(w_s.pos_a[63:32]), r_dpay, w_plus_a),
                   upd(signed'(w_s.pos_a[31:0]),  r_dpax, w_plus_a)}
                : w_s.pos_a;
            r_o_pos_b <= (w_app_p && w_dyn_b)
                ? {upd(signed'(w_s.pos_b[63:32]), r_dpby, !w_plus_a),
                   upd(signed'(w_s.pos_b[31:0]),  r_dpbx, !w_plus_a)}
                : w_s.pos_b;
            r_o_imp <= w_app_v && (w_dyn_a || w_dyn_b);
            r_o_mov <= w_app_p && (w_dyn_a || w_dyn_b);
        end
    end

    assign o_out_valid       = r_vld[NS-1];
    assign o_new_vel_a       = r_o_vel_a;
    assign o_new_vel_b       = r_o_vel_b;
    assign o_new_pos_a       = r_o_pos_a;
    assign o_new_pos_b       = r_o_pos_b;
    assign o_impulse_applied = r_o_imp;
    assign o_moved_apart     = r_o_mov;

endmodule

// ----- rtl/cir_chk.sv -----
// port-level checks for the contact resolver, bound to the top level
`include "contact_impulse_resolver_macros.svh"

module cir_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [63:0]        o_new_vel_a,
    input logic [63:0]        o_new_vel_b,
    input logic [63:0]        o_new_pos_a,
    input logic [63:0]        o_new_pos_b,
    input logic               o_impulse_applied,
    input logic               o_moved_apart
);

    // no result right after reset
    `CIR_ASSERT_RST(a_rst_empty, !i_rst_n, !o_out_valid)
    // a draining output leaves the whole pipe free to take a beat
    `CIR_ASSERT_NOW(a_ready_flow, i_out_ready, o_in_ready)
    // stalled result stays
    `CIR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    // stalled result keeps its payload
    `CIR_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_new_vel_a) && $stable(o_new_vel_b) && $stable(o_new_pos_a) && $stable(o_new_pos_b) && $stable(o_impulse_applied) && $stable(o_moved_apart))

endmodule

bind contact_impulse_resolver cir_chk u_cir_chk (.*);
